// File: rtl/core/sha256_pkg.sv
// Shared types, constants and SHA-256 helper functions for the stream hasher.
package sha256_pkg;

  // Eight 32-bit words, index 0 is word a / H0
  typedef logic [7:0][31:0] hash_t;

  // Sixteen-word block buffer and message schedule window
  typedef logic [15:0][31:0] block_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FIN,
    ST_PAD,
    ST_LEN,
    ST_OUT
  } state_t;

  // Kind of block now being compressed
  typedef enum logic [1:0] {
    BLK_DATA,
    BLK_PAD,
    BLK_LAST
  } blk_t;

  localparam hash_t HASH_IV = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [7:0] PAD_MARK    = 8'h80;
  localparam logic [5:0] LAST_ROUND  = 6'd63;
  localparam logic [5:0] LAST_BYTE   = 6'd63;
  localparam logic [63:0] BYTE_BITS  = 64'd8;

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  // Round constants
  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    unique case (t)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

// File: rtl/core/sha256_round.sv
// One SHA-256 compression round, shared across all 64 rounds of a block.
module sha256_round
  import sha256_pkg::*;
(
  input  hash_t       v_in,
  input  logic [31:0] w,
  input  logic [31:0] k,
  output hash_t       v_out
);

  logic [31:0] e;
  logic [31:0] a;
  logic [31:0] ch;
  logic [31:0] maj;
  logic [31:0] t1;
  logic [31:0] t2;

  // Form the two temporaries
  always_comb begin
    a   = v_in[0];
    e   = v_in[4];
    ch  = (e & v_in[5]) ^ (~e & v_in[6]);
    maj = (a & v_in[1]) ^ (a & v_in[2]) ^ (v_in[1] & v_in[2]);
    t1  = v_in[7] + big_sigma1(e) + ch + k + w;
    t2  = big_sigma0(a) + maj;
  end

  // Rotate the working words
  always_comb begin
    v_out[0] = t1 + t2;
    v_out[1] = v_in[0];
    v_out[2] = v_in[1];
    v_out[3] = v_in[2];
    v_out[4] = v_in[3] + t1;
    v_out[5] = v_in[4];
    v_out[6] = v_in[5];
    v_out[7] = v_in[6];
  end

endmodule

// File: rtl/core/sha256_stream_hasher_core.sv
// Top level of the byte-stream SHA-256 hasher: sequencer, block buffer and hash state.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------------------------
//  item    | in        | item_valid / item_stall   | data_byte, byte_present, end_of_message
//  digest  | out       | digest_valid / digest_stall | digest_word0 .. digest_word3
//
// A byte that does not complete a block leaves the sequencer idle. A completed block
// loads the working words, runs 64 rounds through the single round unit and folds them
// into the hash. An end marker adds one compressed padded block, or a padded and a
// length-only block when the length does not fit, then holds the digest.
// Reset (rst, synchronous) restores the initial hash value; the block buffer is not
// cleared. item_stall is high until the block is free; digest_stall holds the digest.
module sha256_stream_hasher_core
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        end_of_message,
  output logic        digest_valid,
  input  logic        digest_stall,
  output logic [63:0] digest_word0,
  output logic [63:0] digest_word1,
  output logic [63:0] digest_word2,
  output logic [63:0] digest_word3
);

  state_t      state;
  state_t      state_next;
  blk_t        blk;
  logic        end_pend;
  logic [5:0]  fill;
  logic [5:0]  round;
  logic [63:0] bit_count;
  hash_t       hash;
  hash_t       work;
  hash_t       work_next;
  block_t      sched;
  block_t      pad_blk;
  block_t      len_blk;
  logic [31:0] sched_new;
  logic        item_take;
  logic        pad_split;

  // Shared round unit
  sha256_round u_round (
    .v_in  (work),
    .w     (sched[0]),
    .k     (round_k(round)),
    .v_out (work_next)
  );

  assign item_take = item_valid && !item_stall;
  assign pad_split = (fill[5:3] == 3'b111);

  // Next schedule word from the rolling window
  assign sched_new = small_sigma1(sched[14]) + sched[9] + small_sigma0(sched[1]) + sched[0];

  // Build the padded block: keep earlier bytes, mark, zero fill, length if it fits
  always_comb begin
    logic [5:0] pos;
    pos = 6'd0;
    pad_blk = sched;
    for (int i = 0; i < 16; i++) begin
      for (int j = 0; j < 4; j++) begin
        pos = 6'(i * 4 + j);
        if (pos == fill) begin
          pad_blk[i][8*(3-j) +: 8] = PAD_MARK;
        end else if (pos > fill) begin
          pad_blk[i][8*(3-j) +: 8] = 8'h00;
        end
      end
    end
    if (!pad_split) begin
      pad_blk[14] = bit_count[63:32];
      pad_blk[15] = bit_count[31:0];
    end
  end

  // Length-only block after a split pad
  always_comb begin
    len_blk     = '0;
    len_blk[14] = bit_count[63:32];
    len_blk[15] = bit_count[31:0];
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_take) begin
          if (byte_present && fill == LAST_BYTE) begin
            state_next = ST_LOAD;
          end else if (end_of_message) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_LOAD:  state_next = ST_ROUND;
      ST_ROUND: begin
        if (round == LAST_ROUND) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        unique case (blk)
          BLK_DATA: state_next = end_pend ? ST_PAD : ST_IDLE;
          BLK_PAD:  state_next = ST_LEN;
          BLK_LAST: state_next = ST_OUT;
          default:  state_next = ST_IDLE;
        endcase
      end
      ST_PAD:   state_next = ST_LOAD;
      ST_LEN:   state_next = ST_LOAD;
      ST_OUT: begin
        if (!digest_stall) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    item_stall   = (state != ST_IDLE);
    digest_valid = (state == ST_OUT);
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control registers: fill, length, block kind, pending end, round counter, hash
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      bit_count <= '0;
      blk       <= BLK_DATA;
      end_pend  <= 1'b0;
      round     <= '0;
      hash      <= HASH_IV;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (item_take && byte_present) begin
            fill      <= fill + 6'd1;
            bit_count <= bit_count + BYTE_BITS;
            blk       <= BLK_DATA;
            end_pend  <= end_of_message;
          end
        end
        ST_LOAD:  round <= '0;
        ST_ROUND: round <= round + 6'd1;
        ST_FIN: begin
          for (int i = 0; i < 8; i++) begin
            hash[i] <= hash[i] + work[i];
          end
          end_pend <= 1'b0;
        end
        ST_PAD:   blk <= pad_split ? BLK_PAD : BLK_LAST;
        ST_LEN:   blk <= BLK_LAST;
        ST_OUT: begin
          if (!digest_stall) begin
            hash      <= HASH_IV;
            bit_count <= '0;
            fill      <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Block buffer and schedule window, working words
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (item_take && byte_present) begin
          sched[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <= data_byte;
        end
      end
      ST_LOAD:  work <= hash;
      ST_ROUND: begin
        work  <= work_next;
        sched <= {sched_new, sched[15:1]};
      end
      ST_PAD:   sched <= pad_blk;
      ST_LEN:   sched <= len_blk;
      default: ;
    endcase
  end

  // Digest straight from the hash words
  assign digest_word0 = {hash[0], hash[1]};
  assign digest_word1 = {hash[2], hash[3]};
  assign digest_word2 = {hash[4], hash[5]};
  assign digest_word3 = {hash[6], hash[7]};

endmodule

// File: verif/tb_sha256_stream_hasher_core.sv
// Testbench for sha256_stream_hasher_core: byte stimulus, own SHA-256 predictor, digest check.
module tb_sha256_stream_hasher_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 1950;
  localparam int DRAIN_CYCLES = 160;

  localparam bit [255:0] EMPTY_DIGEST =
    256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
  localparam bit [255:0] ABC_DIGEST =
    256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

  localparam bit [0:7][31:0] START_HASH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam bit [0:63][31:0] ROUND_K = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Message lengths around the block and padding boundaries
  localparam bit [0:10][7:0] EDGE_LENS = {
    8'd55, 8'd56, 8'd57, 8'd63, 8'd64, 8'd65, 8'd119, 8'd120, 8'd121, 8'd127, 8'd128
  };

  typedef struct packed {
    bit [7:0]   data;
    bit         present;
    bit         last;
    bit         known;
    bit [255:0] digest;
  } byte_row_t;

  // Directed rows: empty message, "abc", byte extremes, ignored items, stale data on end
  localparam int DIRECTED_ROWS = 15;
  localparam byte_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
    '{8'h61, 1'b1, 1'b0, 1'b0, 256'd0},
    '{8'h62, 1'b1, 1'b0, 1'b0, 256'd0},
    '{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},
    '{8'ha5, 1'b0, 1'b0, 1'b0, 256'd0},
    '{8'h00, 1'b1, 1'b0, 1'b0, 256'd0},
    '{8'hff, 1'b1, 1'b0, 1'b0, 256'd0},
    '{8'h5a, 1'b0, 1'b1, 1'b0, 256'd0},
    '{8'hff, 1'b1, 1'b1, 1'b0, 256'd0},
    '{8'h00, 1'b1, 1'b1, 1'b0, 256'd0},
    '{8'hff, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
    '{8'h00, 1'b0, 1'b0, 1'b0, 256'd0},
    '{8'h80, 1'b1, 1'b0, 1'b0, 256'd0},
    '{8'h7f, 1'b1, 1'b0, 1'b0, 256'd0},
    '{8'h01, 1'b1, 1'b1, 1'b0, 256'd0}
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  logic [7:0]  data_byte;
  logic        byte_present;
  logic        end_of_message;
  logic        digest_valid;
  logic        digest_stall = 1'b0;
  logic [63:0] digest_word0;
  logic [63:0] digest_word1;
  logic [63:0] digest_word2;
  logic [63:0] digest_word3;

  // Predictor state: running hash, partial block, message length in bits
  bit [31:0]  run_hash [0:7];
  bit [7:0]   blk_bytes [0:63];
  int         blk_fill;
  bit [63:0]  msg_bits;

  bit [255:0] pending_digests [$];
  int         errors;
  int         counted_items;
  int         cycle_count;
  int         hold_left;

  sha256_stream_hasher_core uut (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .data_byte      (data_byte),
    .byte_present   (byte_present),
    .end_of_message (end_of_message),
    .digest_valid   (digest_valid),
    .digest_stall   (digest_stall),
    .digest_word0   (digest_word0),
    .digest_word1   (digest_word1),
    .digest_word2   (digest_word2),
    .digest_word3   (digest_word3)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic bit [31:0] ror32(input bit [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void restart_hash();
    for (int i = 0; i < 8; i++) run_hash[i] = START_HASH[i];
    blk_fill = 0;
    msg_bits = '0;
  endfunction

  // Run the 64-round compression over the current block
  function automatic void compress_block();
    bit [31:0] w [0:63];
    bit [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int t = 0; t < 16; t++)
      w[t] = {blk_bytes[4*t], blk_bytes[4*t+1], blk_bytes[4*t+2], blk_bytes[4*t+3]};
    for (int t = 16; t < 64; t++) begin
      s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    a = run_hash[0]; b = run_hash[1]; c = run_hash[2]; d = run_hash[3];
    e = run_hash[4]; f = run_hash[5]; g = run_hash[6]; h = run_hash[7];
    for (int t = 0; t < 64; t++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
         + ROUND_K[t] + w[t];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    run_hash[0] += a; run_hash[1] += b; run_hash[2] += c; run_hash[3] += d;
    run_hash[4] += e; run_hash[5] += f; run_hash[6] += g; run_hash[7] += h;
  endfunction

  // Absorb one transaction; return 1 with the digest when it ends a message
  function automatic bit hash_absorb(input bit [7:0] d, input bit p, input bit e,
                                     output bit [255:0] dig);
    dig = '0;
    if (p) begin
      blk_bytes[blk_fill] = d;
      msg_bits += 64'd8;
      blk_fill++;
      if (blk_fill == 64) begin
        compress_block();
        blk_fill = 0;
      end
    end
    if (!e) return 1'b0;
    blk_bytes[blk_fill] = 8'h80;
    blk_fill++;
    // No room left for the length: close this block and pad a fresh one
    if (blk_fill > 56) begin
      while (blk_fill < 64) begin
        blk_bytes[blk_fill] = 8'h00;
        blk_fill++;
      end
      compress_block();
      blk_fill = 0;
    end
    while (blk_fill < 56) begin
      blk_bytes[blk_fill] = 8'h00;
      blk_fill++;
    end
    for (int i = 0; i < 8; i++) blk_bytes[56+i] = msg_bits[63-8*i -: 8];
    compress_block();
    for (int i = 0; i < 8; i++) dig[255-32*i -: 32] = run_hash[i];
    restart_hash();
    return 1'b1;
  endfunction

  // Drive one transaction, wait for acceptance, then queue its digest if any
  task automatic send_item(input bit [7:0] d, input bit p, input bit e, input bit known,
                           input bit [255:0] typed_dig, input bit bursty);
    int gap;
    bit [255:0] dig;
    gap = bursty ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid     <= 1'b1;
    data_byte      <= d;
    byte_present   <= p;
    end_of_message <= e;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    if (hash_absorb(d, p, e, dig)) begin
      pending_digests.push_back(known ? typed_dig : dig);
    end
    counted_items++;
  endtask

  // Send a message of random bytes with ignored items mixed in
  task automatic send_message(input int len);
    bit bursty;
    bit end_on_byte;
    bursty = ($urandom_range(0, 3) == 0);
    end_on_byte = (len > 0) && $urandom_range(0, 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0, bursty);
      send_item(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (i == len - 1), 1'b0,
                '0, bursty);
    end
    if (!end_on_byte)
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, '0, bursty);
  endtask

  // Check each digest transaction and draw the stall for the next one
  always @(posedge clk) begin
    if (rst) begin
      digest_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (digest_valid && !digest_stall) begin
        if (pending_digests.size() == 0) begin
          $error("unexpected digest %h %h %h %h",
                 digest_word0, digest_word1, digest_word2, digest_word3);
          errors++;
        end else begin
          bit [255:0] want;
          want = pending_digests.pop_front();
          if (digest_word0 !== want[255:192]) begin
            $error("digest_word0: expected %h, got %h", want[255:192], digest_word0);
            errors++;
          end
          if (digest_word1 !== want[191:128]) begin
            $error("digest_word1: expected %h, got %h", want[191:128], digest_word1);
            errors++;
          end
          if (digest_word2 !== want[127:64]) begin
            $error("digest_word2: expected %h, got %h", want[127:64], digest_word2);
            errors++;
          end
          if (digest_word3 !== want[63:0]) begin
            $error("digest_word3: expected %h, got %h", want[63:0], digest_word3);
            errors++;
          end
        end
        hold_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      end else if (digest_valid && hold_left > 0) begin
        hold_left--;
      end
      digest_stall <= (hold_left > 0);
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int len;
    int pick;
    rst            <= 1'b1;
    item_valid     <= 1'b0;
    data_byte      <= 8'h00;
    byte_present   <= 1'b0;
    end_of_message <= 1'b0;
    errors = 0;
    counted_items = 0;
    cycle_count = 0;
    restart_hash();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table
    for (int r = 0; r < DIRECTED_ROWS; r++)
      send_item(DIRECTED[r].data, DIRECTED[r].present, DIRECTED[r].last,
                DIRECTED[r].known, DIRECTED[r].digest, 1'b0);
    counted_items = 0;

    // Random messages, biased toward block and padding boundaries
    while (counted_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 8)       len = 0;
      else if (pick < 40) len = $urandom_range(1, 24);
      else if (pick < 70) len = $urandom_range(50, 70);
      else if (pick < 80) len = $urandom_range(110, 135);
      else if (pick < 90) len = int'(EDGE_LENS[$urandom_range(0, 10)]);
      else                len = $urandom_range(1, 200);
      send_message(len);
    end
    item_valid <= 1'b0;

    // Drain outstanding digests
    while (pending_digests.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
